>>> src/tcst_pkg.sv
`default_nettype none
package tcst_pkg;

    localparam int NUM_SOCKETS = 1024;
    localparam int ADDR_W      = (NUM_SOCKETS > 1) ? $clog2(NUM_SOCKETS) : 1;
    localparam int SOCKET_W    = 10;
    localparam int SEQ_W       = 32;

    typedef enum logic [3:0] {
        ST_CLOSED      = 4'd0,
        ST_LISTEN      = 4'd1,
        ST_SYN_RCVD    = 4'd2,
        ST_SYN_SENT    = 4'd3,
        ST_ESTABLISHED = 4'd4,
        ST_FIN_WAIT_1  = 4'd5,
        ST_FIN_WAIT_2  = 4'd6,
        ST_TIME_WAIT   = 4'd7,
        ST_CLOSE_WAIT  = 4'd9,
        ST_LAST_ACK    = 4'd10
    } t_state;

    typedef struct packed {
        logic [SOCKET_W-1:0] socket_index;
        logic                listen_req;
        logic                open_close_req;
        logic                seg_present;
        logic                seg_syn;
        logic                seg_ack_flag;
        logic                seg_fin;
        logic [SEQ_W-1:0]    seg_seq;
        logic [SEQ_W-1:0]    seg_ack_number;
        logic [SEQ_W-1:0]    fresh_seq;
    } t_req;

    typedef struct packed {
        logic [3:0]       conn_state;
        logic             send_valid;
        logic             send_syn;
        logic             send_ack;
        logic             send_fin;
        logic [SEQ_W-1:0] send_seq;
        logic [SEQ_W-1:0] send_ack_number;
    } t_res;

    // one table row: cached sequence number and connection state
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        t_state           state;
    } t_entry;

endpackage
`default_nettype wire

>>> src/tcst_if.sv
`default_nettype none
interface tcst_req_if;
    logic          valid;
    logic          ready;
    tcst_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcst_res_if;
    logic          valid;
    logic          ready;
    tcst_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/tcst_ram.sv
`default_nettype none
module tcst_ram #(
    parameter int WIDTH  = 36,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [ADDR_W-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [ADDR_W-1:0]        i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> src/tcp_connection_state_table.sv
`default_nettype none
// TCP connection state table, one entry per socket.
// i_req carries one event for one socket: listen / connect-close requests,
// an optional received segment and a fresh initial sequence number.
// o_res returns exactly one beat per request beat: the socket's new state
// and, when send_valid is set, the segment to transmit.
// Pipeline: a request beat and its RAM read are registered in stage 1, then
// its result in the output register. Throughput is one beat per cycle unless
// o_res.ready is low, including back-to-back beats to the same socket; the
// table is a single RAM with one write and one registered read port, and the
// last write is bypassed to the read side to close the read-modify-write loop.
// Reset: after i_rst_n is released the table is swept to CLOSED / zero,
// one entry per cycle across all rows; i_req.ready stays low meanwhile.
// Stall: while o_res.ready is low the block holds one finished result in
// the output register and one request in flight, then drops i_req.ready.
module tcp_connection_state_table (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcst_req_if.sink   i_req,
    tcst_res_if.source o_res
);
    localparam int ENTRY_W = $bits(tcst_pkg::t_entry);
    localparam int ADDR_W  = tcst_pkg::ADDR_W;
    localparam int SEQ_W   = tcst_pkg::SEQ_W;

    // clearing sweep
    logic [ADDR_W:0]   r_clr_cnt;
    logic              r_clr_done;

    // request stage
    logic              r_s1_valid;
    tcst_pkg::t_req    r_s1;

    // last table write, for bypass
    logic              r_wr_valid;
    logic [ADDR_W-1:0] r_wr_addr;
    tcst_pkg::t_entry  r_wr_data;

    // output register
    logic              r_out_valid;
    tcst_pkg::t_res    r_out;

    logic              accept;
    logic              out_free;
    logic              s1_adv;
    logic              in_range;
    logic [ADDR_W-1:0] s1_addr;
    logic [ENTRY_W-1:0] ram_rdata;
    tcst_pkg::t_entry  cur;
    tcst_pkg::t_entry  n_entry;
    tcst_pkg::t_res    n_out;
    logic              rsyn;
    logic              rack;
    logic              rfin;
    logic [SEQ_W-1:0]  rseq_inc;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    tcst_pkg::t_entry  ram_wdata;

    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_adv      = r_s1_valid && out_free;
    assign i_req.ready = r_clr_done && (!r_s1_valid || out_free);
    assign accept      = i_req.valid && i_req.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign s1_addr  = r_s1.socket_index[ADDR_W-1:0];
    assign in_range = 32'(r_s1.socket_index) < 32'(tcst_pkg::NUM_SOCKETS);
    assign cur      = (r_wr_valid && r_wr_addr == s1_addr)
                    ? r_wr_data : tcst_pkg::t_entry'(ram_rdata);

    assign rsyn     = r_s1.seg_present && r_s1.seg_syn;
    assign rack     = r_s1.seg_present && r_s1.seg_ack_flag;
    assign rfin     = r_s1.seg_present && r_s1.seg_fin;
    assign rseq_inc = r_s1.seg_seq + SEQ_W'(1);

    // next table entry and result for the request in stage 1
    always_comb begin
        n_entry = cur;
        n_out   = '0;
        case (cur.state)
            tcst_pkg::ST_CLOSED: begin
                if (r_s1.listen_req) begin
                    n_entry.state = tcst_pkg::ST_LISTEN;
                end else if (r_s1.open_close_req) begin
                    n_entry.state    = tcst_pkg::ST_SYN_SENT;
                    n_entry.seq      = r_s1.fresh_seq;
                    n_out.send_valid = 1'b1;
                    n_out.send_syn   = 1'b1;
                    n_out.send_seq   = r_s1.fresh_seq;
                end
            end
            tcst_pkg::ST_LISTEN: begin
                if (rsyn) begin
                    n_entry.state         = tcst_pkg::ST_SYN_RCVD;
                    n_entry.seq           = r_s1.seg_seq;
                    n_out.send_valid      = 1'b1;
                    n_out.send_syn        = 1'b1;
                    n_out.send_ack        = 1'b1;
                    n_out.send_seq        = r_s1.fresh_seq;
                    n_out.send_ack_number = rseq_inc;
                end
            end
            tcst_pkg::ST_SYN_SENT: begin
                if (rsyn && rack) begin
                    n_entry.state         = tcst_pkg::ST_ESTABLISHED;
                    n_out.send_valid      = 1'b1;
                    n_out.send_ack        = 1'b1;
                    n_out.send_seq        = r_s1.seg_ack_number;
                    n_out.send_ack_number = rseq_inc;
                end else if (rsyn) begin
                    // simultaneous open: resend our SYN with an ACK
                    n_entry.state         = tcst_pkg::ST_SYN_RCVD;
                    n_out.send_valid      = 1'b1;
                    n_out.send_syn        = 1'b1;
                    n_out.send_ack        = 1'b1;
                    n_out.send_seq        = cur.seq;
                    n_out.send_ack_number = rseq_inc;
                end
            end
            tcst_pkg::ST_SYN_RCVD: begin
                if (rack) begin
                    n_entry.state = tcst_pkg::ST_ESTABLISHED;
                end
            end
            tcst_pkg::ST_ESTABLISHED: begin
                if (r_s1.open_close_req) begin
                    n_entry.state    = tcst_pkg::ST_FIN_WAIT_1;
                    n_out.send_valid = 1'b1;
                    n_out.send_fin   = 1'b1;
                end else if (rfin) begin
                    n_entry.state    = tcst_pkg::ST_CLOSE_WAIT;
                    n_out.send_valid = 1'b1;
                    n_out.send_ack   = 1'b1;
                end
            end
            tcst_pkg::ST_FIN_WAIT_1: begin
                if (rack) begin
                    n_entry.state = tcst_pkg::ST_FIN_WAIT_2;
                end
            end
            tcst_pkg::ST_FIN_WAIT_2: begin
                if (rfin) begin
                    n_entry.state    = tcst_pkg::ST_TIME_WAIT;
                    n_out.send_valid = 1'b1;
                    n_out.send_ack   = 1'b1;
                end
            end
            tcst_pkg::ST_CLOSE_WAIT: begin
                if (r_s1.open_close_req) begin
                    n_entry.state    = tcst_pkg::ST_LAST_ACK;
                    n_out.send_valid = 1'b1;
                    n_out.send_fin   = 1'b1;
                end
            end
            tcst_pkg::ST_LAST_ACK: begin
                if (rack) begin
                    n_entry.state = tcst_pkg::ST_CLOSED;
                end
            end
            tcst_pkg::ST_TIME_WAIT: begin
                n_entry.state = tcst_pkg::ST_CLOSED;
            end
            default: begin
            end
        endcase
        n_out.conn_state = 4'(n_entry.state);
        if (!in_range) begin
            n_out = '0;
        end
    end

    // write port: clearing sweep first, then request write-back
    always_comb begin
        if (!r_clr_done) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt[ADDR_W-1:0];
            ram_wdata = '0;
        end else begin
            ram_we    = s1_adv && in_range;
            ram_waddr = s1_addr;
            ram_wdata = n_entry;
        end
    end

    tcst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (tcst_pkg::NUM_SOCKETS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (i_req.data.socket_index[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_clr_done  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_clr_done) begin
                r_clr_cnt <= r_clr_cnt + (ADDR_W+1)'(1);
                if (r_clr_cnt == (ADDR_W+1)'(tcst_pkg::NUM_SOCKETS - 1)) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (ram_we) begin
                r_wr_valid <= 1'b1;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_req.data;
        end
        // keep the most recent write; it is always the newest value of its row
        if (ram_we) begin
            r_wr_addr <= ram_waddr;
            r_wr_data <= ram_wdata;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1))
        else $error("stalled request lost from stage 1");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_done |-> !accept)
        else $error("request accepted during table sweep");

    a_state_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.conn_state != 4'd8 && r_out.conn_state <= 4'd10)
        else $error("result carries an unused state code");

    a_seg_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.send_valid |->
            !r_out.send_syn && !r_out.send_fin && !r_out.send_ack
            && r_out.send_seq == '0 && r_out.send_ack_number == '0)
        else $error("segment fields set with no segment to send");

endmodule
`default_nettype wire
